// ===== design/mid_side_stereo_widener_unit_assert.svh =====
// assertion macros for the mid/side widener
`ifndef MID_SIDE_STEREO_WIDENER_UNIT_ASSERT_SVH
`define MID_SIDE_STEREO_WIDENER_UNIT_ASSERT_SVH

// same-cycle implication
`define MSW_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("msw assertion failed");

// next-cycle implication
`define MSW_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("msw assertion failed");

`endif

// ===== design/msw_pkg.sv =====
// shared constants and control types for the mid/side widener
package msw_pkg;

	localparam int DEF_DELAY_DEPTH = 2048;
	localparam int DEF_SAMPLE_BITS = 24;

	localparam int FILT_FRAC  = 28;
	localparam int COEF_FRAC  = 29;
	localparam int WIDTH_FRAC = 14;
	localparam int Y_BITS     = 31;
	localparam int STATE_BITS = 48;
	localparam int COEF_BITS  = 32;
	localparam int GAIN_BITS  = 16;
	localparam int DELAY_BITS = 11;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_GAIN = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_B0         = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_B1         = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_B2         = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_A1         = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_A2         = 3'd6;

	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd21299;

	typedef enum logic [2:0] {
		MUL_B0,
		MUL_B1,
		MUL_B2,
		MUL_A1,
		MUL_A2,
		MUL_GAIN
	} mul_sel_t;

	typedef struct packed {
		logic     ld_in;
		logic     mem;
		logic     ld_x;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ld_y;
		logic     ld_acc;
		logic     ld_s1;
		logic     ld_s2;
		logic     ld_hp;
		logic     ld_out;
	} cmd_t;

	typedef struct packed {
		logic delay_on;
	} sts_t;

endpackage

// ===== design/msw_ram.sv =====
// generic single write port ram with registered read
module msw_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/msw_ctrl.sv =====
// sequencer for the widener datapath and output handshake
module msw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	output logic          m_valid,
	input  logic          m_ready,
	input  msw_pkg::sts_t sts,
	output msw_pkg::cmd_t cmd
);
	import msw_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEM,
		ST_RD,
		ST_B0,
		ST_Y,
		ST_A1,
		ST_S1,
		ST_A2,
		ST_S2,
		ST_WM,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_B0;
		case (state_q)
			ST_IDLE: cmd.ld_in = s_valid;
			ST_MEM:  cmd.mem = 1'b1;
			ST_RD:   cmd.ld_x = 1'b1;
			ST_B0: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_B0;
			end
			ST_Y: begin
				cmd.ld_y = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_B1;
			end
			ST_A1: begin
				cmd.ld_acc = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_A1;
			end
			ST_S1: begin
				cmd.ld_s1 = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_B2;
			end
			ST_A2: begin
				cmd.ld_acc = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_A2;
			end
			ST_S2: begin
				cmd.ld_s2 = 1'b1;
				cmd.ld_hp = 1'b1;
			end
			ST_WM: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_GAIN;
			end
			ST_OUT:  cmd.ld_out = !out_valid_q || m_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || m_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_valid) begin
						state_q <= sts.delay_on ? ST_MEM : ST_RD;
					end
				end
				ST_MEM:  state_q <= ST_RD;
				ST_RD:   state_q <= ST_B0;
				ST_B0:   state_q <= ST_Y;
				ST_Y:    state_q <= ST_A1;
				ST_A1:   state_q <= ST_S1;
				ST_S1:   state_q <= ST_A2;
				ST_A2:   state_q <= ST_S2;
				ST_S2:   state_q <= ST_WM;
				ST_WM:   state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || m_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/msw_dp.sv =====
// datapath: config registers, delay addressing, shared multiplier, biquad and mixing
module msw_dp #(
	parameter int DELAY_DEPTH = msw_pkg::DEF_DELAY_DEPTH,
	parameter int SAMPLE_BITS = msw_pkg::DEF_SAMPLE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  msw_pkg::cmd_t                      cmd,
	output msw_pkg::sts_t                      sts,
	input  logic signed [SAMPLE_BITS-1:0]      left_in,
	input  logic signed [SAMPLE_BITS-1:0]      right_in,
	input  logic                               cfg_we,
	input  logic [msw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [msw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output logic                               ram_we,
	output logic [$clog2(DELAY_DEPTH)-1:0]     ram_waddr,
	output logic [SAMPLE_BITS-1:0]             ram_wdata,
	output logic [$clog2(DELAY_DEPTH)-1:0]     ram_raddr,
	input  logic [SAMPLE_BITS-1:0]             ram_rdata,
	output logic signed [SAMPLE_BITS-1:0]      left_out,
	output logic signed [SAMPLE_BITS-1:0]      right_out
);
	import msw_pkg::*;

	localparam int AW      = $clog2(DELAY_DEPTH);
	localparam int CW      = (AW + 1 > DELAY_BITS) ? AW + 1 : DELAY_BITS;
	localparam int XF_W    = 30;
	localparam int LOW_W   = SAMPLE_BITS + 4;
	localparam int HP_W    = SAMPLE_BITS + 5;
	localparam int MB      = (HP_W > COEF_BITS) ? HP_W : COEF_BITS;
	localparam int P_W     = COEF_BITS + MB;
	localparam int W       = P_W + 2;
	localparam int SH_DN   = (SAMPLE_BITS < FILT_FRAC) ? FILT_FRAC - SAMPLE_BITS : 0;
	localparam int SH_UP   = (SAMPLE_BITS > FILT_FRAC) ? SAMPLE_BITS - FILT_FRAC : 0;
	localparam int HALF_DN = (SH_DN > 0) ? SH_DN - 1 : 0;
	localparam int HALF_UP = (SH_UP > 0) ? SH_UP - 1 : 0;

	// configuration
	logic [GAIN_BITS-1:0]         gain_q;
	logic [DELAY_BITS-1:0]        delay_q;
	logic signed [COEF_BITS-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;

	// delay line addressing
	logic [AW-1:0]                wi_q;
	logic [AW:0]                  fill_q;
	logic                         rvalid_q;
	logic [CW-1:0]                d_ext, d_sat;
	logic [AW:0]                  d_a, wi_e, ri_e;

	// item and working registers
	logic signed [SAMPLE_BITS-1:0] left_q, right_q, right_eff;
	logic signed [SAMPLE_BITS:0]   x_q, sum_q, x_n;
	logic signed [SAMPLE_BITS+1:0] x_w, x_r;
	logic signed [XF_W-1:0]        xf_q, xf_n;
	logic signed [Y_BITS-1:0]      y_q, y_n;
	logic signed [STATE_BITS-1:0]  s1_q, s2_q, s1_n, s2_n;
	logic signed [HP_W-1:0]        hp_q, hp_n;
	logic signed [LOW_W-1:0]       low;
	logic signed [31:0]            y_r;
	logic signed [COEF_BITS-1:0]   a_op;
	logic signed [MB-1:0]          b_op;
	logic signed [P_W-1:0]         prod_q, acc_q;
	logic signed [W-1:0]           yt, ys, dt, ds, s1v, st, sw, lv, rv, ls, rs;
	logic signed [SAMPLE_BITS-1:0] lo_n, ro_n;

	assign sts.delay_on = (delay_q != '0);

	always_comb begin
		d_ext = CW'(delay_q);
		d_sat = (d_ext > CW'(DELAY_DEPTH - 1)) ? CW'(DELAY_DEPTH - 1) : d_ext;
		d_a   = (AW + 1)'(d_sat);
		wi_e  = (AW + 1)'(wi_q);
		ri_e  = (wi_e >= d_a) ? wi_e - d_a : wi_e + (AW + 1)'(DELAY_DEPTH) - d_a;
	end

	assign ram_we    = cmd.mem;
	assign ram_waddr = wi_q;
	assign ram_wdata = right_q;
	assign ram_raddr = ri_e[AW-1:0];

	// side, sum and scaling into filter units
	always_comb begin
		right_eff = sts.delay_on ? (rvalid_q ? $signed(ram_rdata) : '0) : right_q;
		x_n = (SAMPLE_BITS + 1)'(left_q) - (SAMPLE_BITS + 1)'(right_eff);
		x_w = (SAMPLE_BITS + 2)'(x_n);
		x_r = x_w + ((SAMPLE_BITS + 2)'(1) << HALF_UP);
		if (SH_UP == 0) begin
			xf_n = XF_W'(x_w) <<< SH_DN;
		end else begin
			xf_n = XF_W'(x_r >>> SH_UP);
		end
	end

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_B0:   a_op = b0_q;
			MUL_B1:   a_op = b1_q;
			MUL_B2:   a_op = b2_q;
			MUL_A1:   a_op = a1_q;
			MUL_A2:   a_op = a2_q;
			MUL_GAIN: a_op = $signed(COEF_BITS'(gain_q));
			default:  a_op = '0;
		endcase
		case (cmd.mul_sel)
			MUL_B0, MUL_B1, MUL_B2: b_op = MB'(xf_q);
			MUL_A1, MUL_A2:         b_op = MB'(y_q);
			MUL_GAIN:               b_op = MB'(hp_q);
			default:                b_op = '0;
		endcase
	end

	// filter output, saturated to 31 bits
	always_comb begin
		yt = W'(prod_q) + (W'(1) << (COEF_FRAC - 1));
		ys = yt >>> COEF_FRAC;
		s1v = ys + W'(s1_q);
		if (s1v[W-1:Y_BITS-1] == '0 || s1v[W-1:Y_BITS-1] == '1) begin
			y_n = s1v[Y_BITS-1:0];
		end else begin
			y_n = s1v[W-1] ? {1'b1, {(Y_BITS-1){1'b0}}} : {1'b0, {(Y_BITS-1){1'b1}}};
		end
	end

	// state updates
	always_comb begin
		dt = W'(acc_q) - W'(prod_q) + (W'(1) << (COEF_FRAC - 1));
		ds = dt >>> COEF_FRAC;
		st = ds + W'(s2_q);
		if (st[W-1:STATE_BITS-1] == '0 || st[W-1:STATE_BITS-1] == '1) begin
			s1_n = st[STATE_BITS-1:0];
		end else begin
			s1_n = st[W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}} : {1'b0, {(STATE_BITS-1){1'b1}}};
		end
		if (ds[W-1:STATE_BITS-1] == '0 || ds[W-1:STATE_BITS-1] == '1) begin
			s2_n = ds[STATE_BITS-1:0];
		end else begin
			s2_n = ds[W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}} : {1'b0, {(STATE_BITS-1){1'b1}}};
		end
	end

	// low part back to sample units, high part
	always_comb begin
		y_r = 32'(y_q) + (32'(1) << HALF_DN);
		if (SH_DN > 0) begin
			low = LOW_W'(y_r >>> SH_DN);
		end else begin
			low = LOW_W'(y_q) <<< SH_UP;
		end
		hp_n = HP_W'(x_q) - HP_W'(low);
	end

	// width scaling and output mix
	always_comb begin
		sw = (W'(prod_q) + (W'(1) << (WIDTH_FRAC - 1))) >>> WIDTH_FRAC;
		lv = W'(sum_q) + sw + W'(1);
		rv = W'(sum_q) - sw + W'(1);
		ls = lv >>> 1;
		rs = rv >>> 1;
		if (ls[W-1:SAMPLE_BITS-1] == '0 || ls[W-1:SAMPLE_BITS-1] == '1) begin
			lo_n = ls[SAMPLE_BITS-1:0];
		end else begin
			lo_n = ls[W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		if (rs[W-1:SAMPLE_BITS-1] == '0 || rs[W-1:SAMPLE_BITS-1] == '1) begin
			ro_n = rs[SAMPLE_BITS-1:0];
		end else begin
			ro_n = rs[W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			delay_q <= '0;
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
			wi_q <= '0;
			fill_q <= '0;
			rvalid_q <= 1'b0;
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH_GAIN: gain_q <= cfg_data[GAIN_BITS-1:0];
					REG_DELAY:      delay_q <= cfg_data[DELAY_BITS-1:0];
					REG_B0:         b0_q <= $signed(cfg_data);
					REG_B1:         b1_q <= $signed(cfg_data);
					REG_B2:         b2_q <= $signed(cfg_data);
					REG_A1:         a1_q <= $signed(cfg_data);
					REG_A2:         a2_q <= $signed(cfg_data);
					default:        ;
				endcase
			end
			if (cmd.mem) begin
				// entries past the fill count were never written and read as zero
				rvalid_q <= (ri_e < fill_q);
				wi_q <= (wi_e + (AW + 1)'(1) == (AW + 1)'(DELAY_DEPTH)) ? '0 : wi_q + AW'(1);
				if (fill_q != (AW + 1)'(DELAY_DEPTH)) begin
					fill_q <= fill_q + (AW + 1)'(1);
				end
			end
			if (cmd.ld_s1) begin
				s1_q <= s1_n;
			end
			if (cmd.ld_s2) begin
				s2_q <= s2_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			left_q <= left_in;
			right_q <= right_in;
		end
		if (cmd.ld_x) begin
			x_q <= x_n;
			xf_q <= xf_n;
			sum_q <= (SAMPLE_BITS + 1)'(left_q) + (SAMPLE_BITS + 1)'(right_eff);
		end
		if (cmd.mul_en) begin
			prod_q <= a_op * b_op;
		end
		if (cmd.ld_acc) begin
			acc_q <= prod_q;
		end
		if (cmd.ld_y) begin
			y_q <= y_n;
		end
		if (cmd.ld_hp) begin
			hp_q <= hp_n;
		end
		if (cmd.ld_out) begin
			left_out <= lo_n;
			right_out <= ro_n;
		end
	end

endmodule

// ===== design/mid_side_stereo_widener_unit.sv =====
// mid/side stereo widener top level
// the controller accepts a new pair only in idle, after the previous result is loaded into the output register;
// it steps one shared multiplier through the five biquad products and the width scaling, and a held
// output word (tvalid without tready) stalls it before the next output load
// reset: arst_n clears config to defaults, filter states, delay write index and fill count;
// unwritten delay entries read as zero, so no clearing pass is needed
module mid_side_stereo_widener_unit #(
	parameter int DELAY_DEPTH = msw_pkg::DEF_DELAY_DEPTH,
	parameter int SAMPLE_BITS = msw_pkg::DEF_SAMPLE_BITS,
	localparam int TD_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [TD_W-1:0]                   s_axis_tdata,  // left_in, right_in
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [TD_W-1:0]                   m_axis_tdata,  // left_out, right_out
	input  logic                              cfg_we,
	input  logic [msw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [msw_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import msw_pkg::*;

	`include "mid_side_stereo_widener_unit_assert.svh"

	localparam int AW = $clog2(DELAY_DEPTH);

	cmd_t                          cmd;
	sts_t                          sts;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0]        ram_wdata, ram_rdata;
	logic signed [SAMPLE_BITS-1:0] left_out, right_out;

	msw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	msw_dp #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.left_in   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.right_in  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.left_out  (left_out),
		.right_out (right_out)
	);

	msw_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DELAY_DEPTH)
	) u_delay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_axis_tdata = TD_W'({right_out, left_out});

	`MSW_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`MSW_ASSERT_NXT(a_load_shows_word, clk, arst_n, cmd.ld_out, m_axis_tvalid)
	`MSW_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.ld_out, !m_axis_tvalid || m_axis_tready)
	`MSW_ASSERT_IMP(a_mem_only_delayed, clk, arst_n, cmd.mem, sts.delay_on)

endmodule

// ===== tb/sv/tb_mid_side_stereo_widener_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the mid/side stereo widener with a bit-exact widening predictor
module tb_mid_side_stereo_widener_unit;
	import msw_pkg::*;

	localparam int SB = DEF_SAMPLE_BITS;
	localparam int DEPTH = DEF_DELAY_DEPTH;
	localparam int TD_W = ((2 * SB + 7) / 8) * 8;
	localparam int DRAIN_CYCLES = 24;
	localparam int LIMIT = 200000;

	localparam logic [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
	localparam logic [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};

	// normalised low-pass biquad in Q2.29
	localparam logic [COEF_BITS-1:0] LP_B0 = 32'sd36238786;
	localparam logic [COEF_BITS-1:0] LP_B1 = 32'sd72477573;
	localparam logic [COEF_BITS-1:0] LP_B2 = 32'sd36238786;
	localparam logic [COEF_BITS-1:0] LP_A1 = -32'sd613643452;
	localparam logic [COEF_BITS-1:0] LP_A2 = 32'sd221727687;
	localparam logic [COEF_BITS-1:0] C_MAX = 32'h7FFF_FFFF;
	localparam logic [COEF_BITS-1:0] C_MIN = 32'h8000_0000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [TD_W-1:0]          s_axis_tdata = '0;  // left_in, right_in
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [TD_W-1:0]          m_axis_tdata;       // left_out, right_out
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// predictor state and register copy
	logic [GAIN_BITS-1:0]         gain_q14 = GAIN_RESET;
	logic [DELAY_BITS-1:0]        haas_delay = '0;
	logic signed [COEF_BITS-1:0]  b0_c = '0, b1_c = '0, b2_c = '0, a1_c = '0, a2_c = '0;
	logic signed [SB-1:0]         haas_line [DEPTH];
	int unsigned                  haas_wr = 0;
	longint                       lp_s1 = 0, lp_s2 = 0;

	logic [TD_W-1:0] pair_q [$];
	logic [TD_W-1:0] widened_q [$];
	logic [TD_W-1:0] exp_w;
	int              mismatches = 0;
	int              cycles = 0;
	logic            steady = 1'b0;

	mid_side_stereo_widener_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint rnd_shr(longint v, int s);
		if (s == 0)
			return v;
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic logic [TD_W-1:0] widen_pair(logic [TD_W-1:0] word);
		logic signed [SB-1:0] l_s;
		logic signed [SB-1:0] r_s;
		longint ls, rs, x, xf, y, low, hp, sw, sum;
		int unsigned d, rd;
		logic [TD_W-1:0] res;
		l_s = word[SB-1:0];
		r_s = word[2*SB-1:SB];
		ls = longint'(l_s);
		rs = longint'(r_s);
		d = 32'(haas_delay);
		if (d != 0) begin
			if (d >= DEPTH)
				d = DEPTH - 1;
			haas_line[haas_wr] = r_s;
			rd = (haas_wr >= d) ? haas_wr - d : haas_wr + DEPTH - d;
			rs = longint'(haas_line[rd]);
			haas_wr = (haas_wr + 1 == DEPTH) ? 0 : haas_wr + 1;
		end
		x = ls - rs;
		xf = x * (longint'(1) << (FILT_FRAC - SB));
		y = clamp(rnd_shr(longint'(b0_c) * xf, COEF_FRAC) + lp_s1, STATE_BITS);
		y = clamp(y, Y_BITS);
		lp_s1 = clamp(rnd_shr(longint'(b1_c) * xf - longint'(a1_c) * y, COEF_FRAC) + lp_s2,
			STATE_BITS);
		lp_s2 = clamp(rnd_shr(longint'(b2_c) * xf - longint'(a2_c) * y, COEF_FRAC), STATE_BITS);
		low = rnd_shr(y, FILT_FRAC - SB);
		hp = x - low;
		sw = rnd_shr(hp * longint'(gain_q14), WIDTH_FRAC);
		sum = ls + rs;
		res = '0;
		res[SB-1:0] = SB'(clamp(rnd_shr(sum + sw, 1), SB));
		res[2*SB-1:SB] = SB'(clamp(rnd_shr(sum - sw, 1), SB));
		return res;
	endfunction

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3: return SB'($urandom_range(0, 511) - 256);
			default: return SB'($urandom());
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH_GAIN: gain_q14 = val[GAIN_BITS-1:0];
			REG_DELAY: haas_delay = val[DELAY_BITS-1:0];
			REG_B0: b0_c = val;
			REG_B1: b1_c = val;
			REG_B2: b2_c = val;
			REG_A1: a1_c = val;
			REG_A2: a2_c = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_shape(input logic [GAIN_BITS-1:0] gain, input logic [DELAY_BITS-1:0] dly);
		write_reg(REG_WIDTH_GAIN, CFG_DATA_BITS'(gain));
		write_reg(REG_DELAY, CFG_DATA_BITS'(dly));
	endtask

	task automatic set_filter(input logic [COEF_BITS-1:0] b0, b1, b2, a1, a2);
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
	endtask

	task automatic push_pair(input logic [SB-1:0] l, input logic [SB-1:0] r);
		logic [TD_W-1:0] w;
		w = '0;
		w[SB-1:0] = l;
		w[2*SB-1:SB] = r;
		pair_q.push_back(w);
	endtask

	task automatic drain();
		while (pair_q.size() != 0 || widened_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(input int n);
		logic [SB-1:0] l;
		for (int i = 0; i < n; i++) begin
			l = pick_sample();
			// a quarter of the pairs are mono
			push_pair(l, ($urandom_range(0, 3) == 0) ? l : pick_sample());
		end
		drain();
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				widened_q.push_back(widen_pair(s_axis_tdata));
				void'(pair_q.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pair_q.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pair_q[0];
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (widened_q.size() == 0) begin
					$display("%0t: word with none expected, actual %h", $time, m_axis_tdata);
					mismatches++;
				end else begin
					exp_w = widened_q.pop_front();
					if (m_axis_tdata[SB-1:0] !== exp_w[SB-1:0]) begin
						$display("%0t: left_out expected %0d actual %0d", $time,
							$signed(exp_w[SB-1:0]), $signed(m_axis_tdata[SB-1:0]));
						mismatches++;
					end
					if (m_axis_tdata[2*SB-1:SB] !== exp_w[2*SB-1:SB]) begin
						$display("%0t: right_out expected %0d actual %0d", $time,
							$signed(exp_w[2*SB-1:SB]), $signed(m_axis_tdata[2*SB-1:SB]));
						mismatches++;
					end
				end
			end
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++)
			haas_line[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, filter off
		push_pair('0, '0);
		push_pair(S_MAX, S_MAX);
		push_pair(S_MIN, S_MIN);
		push_pair(S_MAX, S_MIN);
		push_pair(S_MIN, S_MAX);
		push_pair(24'sd1, -24'sd1);
		push_pair(-24'sd1, 24'sd1);
		push_pair(-24'sd1, -24'sd1);
		push_pair(24'h555555, 24'hAAAAAA);
		push_pair(24'hAAAAAA, 24'h555555);
		push_pair(S_MAX, '0);
		push_pair('0, S_MIN);
		drain();

		// low-pass, unity width, one sample delay: impulse response
		set_filter(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2);
		set_shape(16'd16384, 11'd1);
		push_pair(S_MAX, '0);
		push_pair('0, '0);
		push_pair('0, '0);
		push_pair('0, '0);
		push_pair(S_MIN, S_MAX);
		push_pair(S_MAX, S_MIN);
		drain();
		run_random(200);

		// extreme coefficients drive the filter into saturation, longest delay, zero width
		set_filter(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
		set_shape(16'd0, 11'd2047);
		push_pair(S_MAX, S_MIN);
		push_pair(S_MIN, S_MAX);
		push_pair(S_MAX, S_MIN);
		drain();
		run_random(150);

		set_filter(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2);
		set_shape(16'd32768, 11'd5);
		run_random(300);

		// width above range, delay bypassed, random filter
		set_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		set_shape(16'hFFFF, 11'd0);
		run_random(150);

		// shorter delay reads stale store contents; no idling here
		set_filter(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2);
		set_shape(GAIN_BITS'($urandom_range(16384, 32768)), 11'd3);
		steady = 1'b1;
		run_random(300);
		steady = 1'b0;

		for (int k = 0; k < 5; k++) begin
			if (k[0])
				set_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
			else
				set_filter(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2);
			set_shape(GAIN_BITS'($urandom_range(0, 65535)),
				DELAY_BITS'($urandom_range(0, 2047)));
			run_random(100);
		end

		if (mismatches == 0 && widened_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
